[rtl/skt_pkg.sv]
`default_nettype none

package skt_pkg;

    // Table geometry.
    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 16;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    // Operation codes carried by the mode field.
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef logic [KEY_WIDTH-1:0] key_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [CNT_W-1:0]     count_t;

    // One table entry as held in the store.
    typedef struct packed {
        key_t        key;
        logic [7:0]  tree;
        logic [31:0] offset;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Flags from the shared key comparator.
    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_PUT,
        ST_LKP,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

[rtl/sorted_key_table.sv]
// Channel   Handshake             Fields
// req       req_valid/req_stall   mode, key, payload_offset, payload_tree
// rsp       rsp_valid/rsp_stall   status, found_offset, found_tree, occupancy
//
// Clear and the unused mode go from acceptance straight to the finish state.
// Lookup walks the table upwards, one entry a cycle, to the first equal key or the top entry.
// Insert walks downwards, moving each entry not below the new key up one place as
// soon as it comes out of the registered read port; the single RAM port pair sets the pace.
// Reset clears the sequencer, the result valid flag and the entry count; the
// store needs no clearing pass.
// A finished result waits in the output register, and the next transaction
// is accepted meanwhile; a stalled result holds the sequencer before IDLE.
`default_nettype none

module sorted_key_table (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [15:0] key,
    input  wire logic [31:0] payload_offset,
    input  wire logic [7:0]  payload_tree,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic [1:0]       status,
    output logic [31:0]      found_offset,
    output logic [7:0]       found_tree,
    output logic [6:0]       occupancy
);
    import skt_pkg::*;

    state_t      state_reg, state_next;
    count_t      count_reg, count_next;
    addr_t       ptr_reg, ptr_next;
    key_t        key_reg;
    logic [31:0] offset_reg;
    logic [7:0]  tree_reg;
    logic [1:0]  res_status_reg, res_status_next;
    logic [31:0] res_offset_reg, res_offset_next;
    logic [7:0]  res_tree_reg, res_tree_next;
    logic        rsp_valid_reg, rsp_valid_next;
    logic [1:0]  status_reg;
    logic [31:0] found_offset_reg;
    logic [7:0]  found_tree_reg;
    count_t      occupancy_reg;

    logic        accept;
    logic        load_out;
    key_t        in_key;
    count_t      count_m1;
    addr_t       ptr_up;
    addr_t       rd_addr;
    logic        wr_en;
    addr_t       wr_addr;
    entry_t      wr_data;
    entry_t      rd_data;
    entry_t      new_entry;
    cmp_t        flags;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign in_key    = key[KEY_WIDTH-1:0];
    assign count_m1  = count_reg - count_t'(1);
    assign ptr_up    = ptr_reg + addr_t'(1);
    assign new_entry = '{key: key_reg, tree: tree_reg, offset: offset_reg};
    assign load_out  = (state_reg == ST_FIN) && (!rsp_valid_reg || !rsp_stall);

    // Entry store.
    skt_ram #(
        .DEPTH(CAPACITY),
        .WIDTH(ENTRY_W)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // Shared comparator for both the insert and the lookup walk.
    skt_cmp u_cmp (
        .stored_key(rd_data.key),
        .target_key(key_reg),
        .flags     (flags)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
        res_tree_reg   <= res_tree_next;
        if (accept)
        begin
            key_reg    <= in_key;
            offset_reg <= payload_offset;
            tree_reg   <= payload_tree;
        end
        if (load_out)
        begin
            status_reg       <= res_status_reg;
            found_offset_reg <= res_offset_reg;
            found_tree_reg   <= res_tree_reg;
            occupancy_reg    <= count_reg;
        end
    end

    // Sequencer: next state, store accesses and result.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        res_status_next = res_status_reg;
        res_offset_next = res_offset_reg;
        res_tree_next   = res_tree_reg;
        rd_addr         = ptr_reg;
        wr_en           = 1'b0;
        wr_addr         = ptr_up;
        wr_data         = rd_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = STATUS_OK;
                    res_offset_next = '0;
                    res_tree_next   = '0;
                    state_next      = ST_FIN;
                    unique case (mode)
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                        end
                        MODE_INSERT:
                        begin
                            if (count_reg == count_t'(CAPACITY))
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                // Empty table: the new entry goes straight to the bottom.
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                wr_data    = '{key: in_key, tree: payload_tree,
                                               offset: payload_offset};
                                count_next = count_t'(1);
                            end
                            else
                            begin
                                // Start at the top entry and walk down.
                                rd_addr    = count_m1[ADDR_W-1:0];
                                ptr_next   = count_m1[ADDR_W-1:0];
                                state_next = ST_INS;
                            end
                        end
                        MODE_LOOKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STATUS_MISS;
                            end
                            else
                            begin
                                rd_addr    = '0;
                                ptr_next   = '0;
                                state_next = ST_LKP;
                            end
                        end
                        default:
                        begin
                            // Unused code: nothing changes.
                        end
                    endcase
                end
            end

            ST_INS:
            begin
                wr_en = 1'b1;
                if (!flags.lt)
                begin
                    // Entry not below the new key moves up by one place.
                    wr_data = rd_data;
                    if (ptr_reg == '0)
                    begin
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        rd_addr  = ptr_reg - addr_t'(1);
                        ptr_next = ptr_reg - addr_t'(1);
                    end
                end
                else
                begin
                    // Lower bound found just above this entry.
                    wr_data    = new_entry;
                    count_next = count_reg + count_t'(1);
                    state_next = ST_FIN;
                end
            end

            ST_PUT:
            begin
                // Every entry moved up: the new key is the smallest.
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = new_entry;
                count_next = count_reg + count_t'(1);
                state_next = ST_FIN;
            end

            ST_LKP:
            begin
                if (flags.eq)
                begin
                    res_offset_next = rd_data.offset;
                    res_tree_next   = rd_data.tree;
                    state_next      = ST_FIN;
                end
                else if (count_t'(ptr_reg) + count_t'(1) == count_reg)
                begin
                    res_status_next = STATUS_MISS;
                    state_next      = ST_FIN;
                end
                else
                begin
                    rd_addr  = ptr_up;
                    ptr_next = ptr_up;
                end
            end

            ST_FIN:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign found_offset = found_offset_reg;
    assign found_tree   = found_tree_reg;
    assign occupancy    = 7'(occupancy_reg);

endmodule

`default_nettype wire

[rtl/skt_ram.sv]
`default_nettype none

module skt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 56
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, read on every cycle.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/skt_cmp.sv]
`default_nettype none

module skt_cmp (
    input  wire skt_pkg::key_t stored_key,
    input  wire skt_pkg::key_t target_key,
    output skt_pkg::cmp_t      flags
);
    import skt_pkg::*;

    // Ordering and equality of the entry just read against the search key.
    assign flags.lt = (stored_key < target_key);
    assign flags.eq = (stored_key == target_key);

endmodule

`default_nettype wire

[rtl/skt_check.sv]
`default_nettype none

module skt_check (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_stall,
    input wire logic        rsp_valid,
    input wire logic        rsp_stall,
    input wire logic [1:0]  status,
    input wire logic [31:0] found_offset,
    input wire logic [7:0]  found_tree,
    input wire logic [6:0]  occupancy
);
    import skt_pkg::*;

    // Only one transaction is worked on at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while a transaction was in progress");

    // The table never reports more entries than it can hold.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> occupancy <= 7'(CAPACITY))
        else $error("occupancy above capacity");

    // A full report only comes from a full table.
    a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == STATUS_FULL |-> occupancy == 7'(CAPACITY))
        else $error("full status with spare room");

    // Found fields are zero unless the operation succeeded.
    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != STATUS_OK |-> found_offset == '0 && found_tree == '0)
        else $error("found fields set on a failed operation");

    // A stalled result holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status)
            && $stable(found_offset) && $stable(found_tree) && $stable(occupancy))
        else $error("stalled result changed");

endmodule

bind sorted_key_table skt_check u_skt_check (.*);

`default_nettype wire

[tb/sv/sorted_key_table_tb.sv]
`default_nettype none

module sorted_key_table_tb;

    import skt_pkg::*;

    // The fourth encoding of the mode field is left unused by the block.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 600;
    localparam int DRAIN_CYCLES   = 80;

    // Shadow copy of the sorted table and the queue of results still owed by the block.
    class sorted_table_tracker;
        typedef struct {
            logic [1:0]  status;
            logic [31:0] offset;
            logic [7:0]  tree;
            logic [6:0]  occupancy;
        } table_result_t;

        key_t          keys [CAPACITY];
        logic [31:0]   offsets [CAPACITY];
        logic [7:0]    trees [CAPACITY];
        int            entries;
        table_result_t pending_results [$];
        int            errors;
        int            hits;
        int            misses;
        int            refused;
        int            peak;

        function new();
            entries = 0;
            errors  = 0;
            hits    = 0;
            misses  = 0;
            refused = 0;
            peak    = 0;
        endfunction

        // Apply one accepted request to the shadow table and queue the result it owes.
        function void note_request(input logic [1:0] op, input key_t k,
                                   input logic [31:0] off, input logic [7:0] tr);
            table_result_t r;
            int            slot;
            int            i;
            r.status = STATUS_OK;
            r.offset = '0;
            r.tree   = '0;
            case (op)
                MODE_CLEAR:
                begin
                    entries = 0;
                end
                MODE_INSERT:
                begin
                    if (entries >= CAPACITY)
                    begin
                        r.status = STATUS_FULL;
                        refused++;
                    end
                    else
                    begin
                        // The new entry goes before any existing entries with an equal key.
                        slot = 0;
                        while (slot < entries && keys[slot] < k)
                            slot++;
                        for (i = entries; i > slot; i--)
                        begin
                            keys[i]    = keys[i-1];
                            offsets[i] = offsets[i-1];
                            trees[i]   = trees[i-1];
                        end
                        keys[slot]    = k;
                        offsets[slot] = off;
                        trees[slot]   = tr;
                        entries++;
                    end
                end
                MODE_LOOKUP:
                begin
                    // The lowest matching position holds the most recent insert of that key.
                    r.status = STATUS_MISS;
                    for (i = 0; i < entries && r.status == STATUS_MISS; i++)
                    begin
                        if (keys[i] == k)
                        begin
                            r.status = STATUS_OK;
                            r.offset = offsets[i];
                            r.tree   = trees[i];
                        end
                    end
                    if (r.status == STATUS_OK)
                        hits++;
                    else
                        misses++;
                end
                default:
                begin
                end
            endcase
            if (entries > peak)
                peak = entries;
            r.occupancy = 7'(entries);
            pending_results.push_back(r);
        endfunction

        // Compare one accepted result with the oldest result still owed.
        function void check_response(input logic [1:0] st, input logic [31:0] off,
                                     input logic [7:0] tr, input logic [6:0] occ);
            table_result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no transaction outstanding: status %0d, occupancy %0d",
                         $time, st, occ);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (st !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, st);
                    errors++;
                end
                if (off !== want.offset)
                begin
                    $display("%0t: found_offset mismatch: expected %h, actual %h",
                             $time, want.offset, off);
                    errors++;
                end
                if (tr !== want.tree)
                begin
                    $display("%0t: found_tree mismatch: expected %h, actual %h",
                             $time, want.tree, tr);
                    errors++;
                end
                if (occ !== want.occupancy)
                begin
                    $display("%0t: occupancy mismatch: expected %0d, actual %0d",
                             $time, want.occupancy, occ);
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        req_valid      = 1'b0;
    logic        req_stall;
    logic [1:0]  mode           = MODE_CLEAR;
    logic [15:0] key            = '0;
    logic [31:0] payload_offset = '0;
    logic [7:0]  payload_tree   = '0;
    logic        rsp_valid;
    logic        rsp_stall      = 1'b0;
    logic [1:0]  status;
    logic [31:0] found_offset;
    logic [7:0]  found_tree;
    logic [6:0]  occupancy;

    sorted_table_tracker tracker;
    bit                  quiet = 1'b0;
    int                  sent  = 0;

    sorted_key_table u_top (.*);

    always #5 clk = ~clk;

    // The result side holds off at random, except during the quiet stretch.
    always @(negedge clk)
        rsp_stall <= !quiet && ($urandom_range(0, 99) < 7);

    // Every accepted result is checked at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            tracker.check_response(status, found_offset, found_tree, occupancy);
    end

    // Give up if no transaction moves on either channel for too long.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("sorted_key_table_tb NOT OK");
        $finish;
    end

    // Present one request from a falling edge and hold it until the block takes it.
    task automatic send_request(input logic [1:0] op, input logic [15:0] k,
                                input logic [31:0] off, input logic [7:0] tr);
        if (!quiet && $urandom_range(0, 99) < 7)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req_valid      <= 1'b1;
        mode           <= op;
        key            <= k;
        payload_offset <= off;
        payload_tree   <= tr;
        do
            @(posedge clk);
        while (req_stall);
        tracker.note_request(op, k, off, tr);
        sent++;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [15:0] key_pool [16];
        logic [15:0] k;
        logic [31:0] off;
        logic [1:0]  op;
        int          segment;
        int          run_len;
        int          insert_pct;
        int          roll;
        int          j;
        bit          fill;

        tracker = new();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: empty table, key and payload extremes, duplicates, unused mode, clear.
        send_request(MODE_LOOKUP, 16'h1234, 32'h0, 8'h00);
        send_request(MODE_INSERT, 16'h8000, 32'hFFFF_FFFF, 8'hFF);
        send_request(MODE_INSERT, 16'h0000, 32'h0000_0000, 8'h00);
        send_request(MODE_INSERT, 16'hFFFF, 32'hA5A5_A5A5, 8'h5A);
        send_request(MODE_INSERT, 16'h8000, 32'h1234_5678, 8'h01);
        send_request(MODE_LOOKUP, 16'h8000, 32'hFFFF_FFFF, 8'hFF);
        send_request(MODE_LOOKUP, 16'h0000, 32'h0, 8'h00);
        send_request(MODE_LOOKUP, 16'hFFFF, 32'h0, 8'h00);
        send_request(MODE_LOOKUP, 16'h7FFF, 32'h0, 8'h00);
        send_request(MODE_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
        send_request(MODE_INSERT, 16'h0001, 32'h8000_0000, 8'h80);
        send_request(MODE_INSERT, 16'h8000, 32'h0000_0001, 8'h7F);
        send_request(MODE_LOOKUP, 16'h0001, 32'h0, 8'h00);
        send_request(MODE_LOOKUP, 16'h8000, 32'h0, 8'h00);
        send_request(MODE_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
        send_request(MODE_LOOKUP, 16'h8000, 32'h0, 8'h00);
        send_request(MODE_INSERT, 16'hFFFF, 32'h5A5A_5A5A, 8'hA5);
        send_request(MODE_LOOKUP, 16'hFFFF, 32'h0, 8'h00);
        send_request(MODE_UNUSED, 16'h0000, 32'h0, 8'h00);
        send_request(MODE_LOOKUP, 16'h0000, 32'h0, 8'h00);

        // Random part in segments, each with its own small pool of keys so that
        // lookups hit and duplicates pile up; fill segments drive the table past full.
        segment = 0;
        while (sent < RANDOM_ITEMS)
        begin
            fill = (segment == 0) || ($urandom_range(0, 3) == 0);
            for (j = 0; j < 16; j++)
                key_pool[j] = 16'($urandom);
            if ($urandom_range(0, 1) == 1)
                key_pool[0] = 16'h0000;
            if ($urandom_range(0, 1) == 1)
                key_pool[15] = 16'hFFFF;
            if (segment == 0 || $urandom_range(0, 1) == 1)
                send_request(MODE_CLEAR, 16'($urandom), $urandom, 8'($urandom_range(0, 255)));
            run_len    = fill ? 85 : $urandom_range(10, 50);
            insert_pct = fill ? 85 : $urandom_range(30, 70);
            for (j = 0; j < run_len; j++)
            begin
                quiet = (sent >= 200) && (sent < 350);
                roll  = $urandom_range(0, 99);
                if (roll < 2)
                    op = MODE_UNUSED;
                else if (roll < 2 + insert_pct)
                    op = MODE_INSERT;
                else
                    op = MODE_LOOKUP;
                if ($urandom_range(0, 9) == 0)
                    k = 16'($urandom);
                else
                    k = key_pool[$urandom_range(0, 15)];
                case ($urandom_range(0, 9))
                    0: off = 32'h0000_0000;
                    1: off = 32'hFFFF_FFFF;
                    default: off = $urandom;
                endcase
                send_request(op, k, off, 8'($urandom_range(0, 255)));
            end
            segment++;
        end
        quiet = 1'b0;
        req_valid <= 1'b0;

        // Wait for every owed result, then give the block time to show any stray one.
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d transactions: %0d lookup hits, %0d lookup misses, %0d inserts refused.",
                 sent, tracker.hits, tracker.misses, tracker.refused);
        $display("Occupancy reached %0d of %0d over %0d segments; %0d mismatches.",
                 tracker.peak, CAPACITY, segment, tracker.errors);
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("sorted_key_table_tb OK");
        else
            $display("sorted_key_table_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/skt_pkg.sv
rtl/skt_ram.sv
rtl/skt_cmp.sv
rtl/sorted_key_table.sv
rtl/skt_check.sv
tb/sv/sorted_key_table_tb.sv
